/* rtl/spn_pkg.sv */
// ----------------------------------------------------------------------------
// spn_pkg
// Shared types, reset constants and round functions for the 16-bit SPN.
// ----------------------------------------------------------------------------
package spn_pkg;

    localparam int BLOCK_W = 16;
    localparam int KEY_W   = 32;
    localparam int TABLE_W = 64;
    localparam int ROUNDS  = 4;

    // configuration register indexes
    localparam logic [1:0] REG_KEY  = 2'd0;
    localparam logic [1:0] REG_SBOX = 2'd1;
    localparam logic [1:0] REG_PERM = 2'd2;

    localparam logic [KEY_W-1:0]   KEY_RESET  = 32'h0000_0000;
    localparam logic [TABLE_W-1:0] SBOX_RESET = 64'hE4D1_2FB8_3A6C_5907;
    localparam logic [TABLE_W-1:0] PERM_RESET = 64'h048C_159D_26AE_37BF;

    // one request moving between neighboring cells
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] data;
    } link_t;

    // four nibble lookups, entry 0 in the top nibble of the table
    function automatic logic [BLOCK_W-1:0] substitute(
        input logic [BLOCK_W-1:0] u,
        input logic [TABLE_W-1:0] sbox
    );
        logic [BLOCK_W-1:0] res;
        logic [3:0]         slot;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            slot = 4'd15 - u[i*4 +: 4];
            res[i*4 +: 4] = sbox[{slot, 2'b00} +: 4];
        end
        return res;
    endfunction

    // input position i goes to output position perm[i]; the later entry wins
    function automatic logic [BLOCK_W-1:0] permute(
        input logic [BLOCK_W-1:0] v,
        input logic [TABLE_W-1:0] perm
    );
        logic [BLOCK_W-1:0] res;
        logic [3:0]         dest;
        logic [3:0]         src;
        res = '0;
        for (int i = 0; i < 16; i++) begin
            src  = 4'd15 - 4'(i);
            dest = perm[{src, 2'b00} +: 4];
            res[4'd15 - dest] = v[src];
        end
        return res;
    endfunction

endpackage

/* rtl/spn_round_cell.sv */
// ----------------------------------------------------------------------------
// spn_round_cell
// One round of the network: key mix, substitution, optional bit permutation,
// registered, with a ready chain toward the upstream neighbor.
// ----------------------------------------------------------------------------
module spn_round_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spn_pkg::link_t                  up,
    output logic                            up_ready,
    output spn_pkg::link_t                  dn,
    input  logic                            dn_ready,
    input  logic [spn_pkg::BLOCK_W-1:0]     round_key,
    input  logic [spn_pkg::TABLE_W-1:0]     sbox,
    input  logic [spn_pkg::TABLE_W-1:0]     perm,
    input  logic                            use_perm
);

    logic                        valid_reg;
    logic [spn_pkg::BLOCK_W-1:0] data_reg;
    logic [spn_pkg::BLOCK_W-1:0] mixed;
    logic [spn_pkg::BLOCK_W-1:0] data_next;

    // take a new request when empty or when the neighbor drains this one
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        mixed = spn_pkg::substitute(up.data ^ round_key, sbox);
        if (use_perm)
        begin
            data_next = spn_pkg::permute(mixed, perm);
        end
        else
        begin
            data_next = mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn.valid = valid_reg;
    assign dn.data  = data_reg;

endmodule

/* rtl/spn_block_encrypt_16bit.sv */
// ----------------------------------------------------------------------------
// spn_block_encrypt_16bit
// Four-round 16-bit substitution-permutation block encryptor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / plaintext. A block is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall / ciphertext, same rule.
//   Configuration: wr_en / wr_index / wr_data write cipher_key (index 0),
//   sbox_table (1) and perm_table (2) at the edge where wr_en is high; other
//   indexes are ignored. Write only while no block is in flight.
// Timing:
//   A row of four round cells, one register each. A block taken at the input
//   passes through the registers of cells 0, 1, 2 and 3 in turn and shows on
//   the output once it sits in cell 3. The cells hand data forward every
//   cycle while out_stall is low, so one block per cycle is sustained.
//   The final key XOR is applied at the output of the last cell.
// Reset:
//   rst_n clears every cell valid bit and loads the default key and tables.
// Stall:
//   When out_stall holds the last cell, earlier cells keep filling bubbles;
//   in_stall rises only once all four cells hold a waiting block.
// ----------------------------------------------------------------------------
module spn_block_encrypt_16bit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [spn_pkg::BLOCK_W-1:0]     plaintext,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [spn_pkg::BLOCK_W-1:0]     ciphertext,
    input  logic                            wr_en,
    input  logic [1:0]                      wr_index,
    input  logic [spn_pkg::TABLE_W-1:0]     wr_data
);

    logic [spn_pkg::KEY_W-1:0]   key_reg;
    logic [spn_pkg::TABLE_W-1:0] sbox_reg;
    logic [spn_pkg::TABLE_W-1:0] perm_reg;

    spn_pkg::link_t link [spn_pkg::ROUNDS+1];
    logic           ready [spn_pkg::ROUNDS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= spn_pkg::KEY_RESET;
            sbox_reg <= spn_pkg::SBOX_RESET;
            perm_reg <= spn_pkg::PERM_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                spn_pkg::REG_KEY:  key_reg  <= wr_data[spn_pkg::KEY_W-1:0];
                spn_pkg::REG_SBOX: sbox_reg <= wr_data;
                spn_pkg::REG_PERM: perm_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign link[0].valid = in_valid;
    assign link[0].data  = plaintext;
    assign in_stall      = !ready[0];

    genvar g;
    generate
        for (g = 0; g < spn_pkg::ROUNDS; g++)
        begin : g_cell
            spn_round_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up        (link[g]),
                .up_ready  (ready[g]),
                .dn        (link[g+1]),
                .dn_ready  (ready[g+1]),
                .round_key (key_reg[spn_pkg::KEY_W-1-4*g -: spn_pkg::BLOCK_W]),
                .sbox      (sbox_reg),
                .perm      (perm_reg),
                .use_perm  (g != spn_pkg::ROUNDS-1)
            );
        end
    endgenerate

    assign ready[spn_pkg::ROUNDS] = !out_stall;
    assign out_valid  = link[spn_pkg::ROUNDS].valid;
    // final whitening with the last round key
    assign ciphertext = link[spn_pkg::ROUNDS].data ^ key_reg[spn_pkg::BLOCK_W-1:0];

    // input backs up only when every cell holds a waiting block
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (link[1].valid && link[2].valid && link[3].valid
                      && link[4].valid && out_stall))
        else $error("input stalled while a cell is empty");

    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty last cell");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> link[1].valid)
        else $error("accepted block did not reach the first cell");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(link[4].data)))
        else $error("stalled result changed in the last cell");

endmodule

/* test/spn_block_encrypt_16bit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spn_block_encrypt_16bit_test
// Self-checking bench for the 16-bit four-round SPN encryptor. Plaintext
// blocks are fed in bursts with random gaps, while the ciphertext side stalls
// on a rolling pattern. An in-bench cipher model predicts every block from
// its own copy of the key and tables. Key, S-box and permutation are
// rewritten between sets of blocks, once the block has gone quiet.
// ----------------------------------------------------------------------------
module spn_block_encrypt_16bit_test;

    localparam logic [1:0] REG_SPARE = 2'd3;   // index with no register behind it

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [spn_pkg::BLOCK_W-1:0]  plaintext = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [spn_pkg::BLOCK_W-1:0]  ciphertext;
    logic                         wr_en     = 1'b0;
    logic [1:0]                   wr_index  = spn_pkg::REG_KEY;
    logic [spn_pkg::TABLE_W-1:0]  wr_data   = '0;

    // bench copy of the configuration
    logic [spn_pkg::KEY_W-1:0]    key_cfg  = spn_pkg::KEY_RESET;
    logic [spn_pkg::TABLE_W-1:0]  sbox_cfg = spn_pkg::SBOX_RESET;
    logic [spn_pkg::TABLE_W-1:0]  perm_cfg = spn_pkg::PERM_RESET;

    logic [spn_pkg::BLOCK_W-1:0]  plain_pending[$];
    logic [spn_pkg::BLOCK_W-1:0]  cipher_expected[$];

    int mismatch_count = 0;
    int blocks_sent    = 0;
    int blocks_checked = 0;
    int settings_used  = 1;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_tick     = 0;

    spn_block_encrypt_16bit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---- cipher model ------------------------------------------------------

    // nibble i counted from the MSB looks up entry nib, entry 0 in the top nibble
    function automatic logic [spn_pkg::BLOCK_W-1:0] sbox_layer(
        input logic [spn_pkg::BLOCK_W-1:0] u,
        input logic [spn_pkg::TABLE_W-1:0] tbl
    );
        logic [spn_pkg::BLOCK_W-1:0] res;
        int                          nib;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            nib = int'(u[15-4*i -: 4]);
            res[15-4*i -: 4] = tbl[63-4*nib -: 4];
        end
        return res;
    endfunction

    // walk positions in order so a repeated destination keeps the last writer
    function automatic logic [spn_pkg::BLOCK_W-1:0] perm_layer(
        input logic [spn_pkg::BLOCK_W-1:0] v,
        input logic [spn_pkg::TABLE_W-1:0] tbl
    );
        logic [spn_pkg::BLOCK_W-1:0] res;
        int                          dest;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            dest = int'(tbl[63-4*i -: 4]);
            res[15-dest] = v[15-i];
        end
        return res;
    endfunction

    function automatic logic [spn_pkg::BLOCK_W-1:0] round_key(input int r);
        return key_cfg[31-4*r -: 16];
    endfunction

    function automatic logic [spn_pkg::BLOCK_W-1:0] encrypt_block(
        input logic [spn_pkg::BLOCK_W-1:0] pt
    );
        logic [spn_pkg::BLOCK_W-1:0] w;
        w = pt;
        for (int r = 0; r < 3; r++)
            w = perm_layer(sbox_layer(w ^ round_key(r), sbox_cfg), perm_cfg);
        return sbox_layer(w ^ round_key(3), sbox_cfg) ^ round_key(4);
    endfunction

    // random arrangement of 0..15, one per nibble
    function automatic logic [spn_pkg::TABLE_W-1:0] shuffled_table();
        int                          slot[16];
        int                          j;
        int                          t;
        logic [spn_pkg::TABLE_W-1:0] res;
        for (int i = 0; i < 16; i++)
            slot[i] = i;
        for (int i = 15; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = slot[i];
            slot[i] = slot[j];
            slot[j] = t;
        end
        for (int i = 0; i < 16; i++)
            res[63-4*i -: 4] = 4'(slot[i]);
        return res;
    endfunction

    function automatic logic [spn_pkg::TABLE_W-1:0] random_word64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ---- request driver ----------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            plaintext <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cipher_expected.push_back(encrypt_block(plaintext));
                void'(plain_pending.pop_front());
                blocks_sent++;
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled request
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (plain_pending.size() > 0)
            begin
                in_valid  <= 1'b1;
                plaintext <= plain_pending[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---- result monitor ----------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        logic [spn_pkg::BLOCK_W-1:0] want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_expected.size() == 0)
                    report_mismatch($sformatf("ciphertext %h with no request waiting",
                                              ciphertext));
                else
                begin
                    want = cipher_expected.pop_front();
                    if (ciphertext !== want)
                        report_mismatch($sformatf("ciphertext %h, expected %h",
                                                  ciphertext, want));
                    blocks_checked++;
                end
            end
            // rotate through stall styles chosen by stall_tick bits 8:6
            stall_tick++;
            case (stall_tick[8:6])
                3'd0, 3'd1: out_stall <= 1'b0;
                3'd2, 3'd3: out_stall <= ($urandom_range(0, 9) < 3);
                3'd4, 3'd5: out_stall <= ($urandom_range(0, 9) < 7);
                3'd6:       out_stall <= stall_tick[2];
                default:    out_stall <= (stall_tick[5:3] == 3'd7);
            endcase
        end
    end

    // ---- configuration and stimulus ----------------------------------------

    task automatic wait_idle();
        do
            @(negedge clk);
        while (plain_pending.size() != 0 || cipher_expected.size() != 0 || in_valid);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [spn_pkg::TABLE_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            spn_pkg::REG_KEY:  key_cfg  = val[spn_pkg::KEY_W-1:0];
            spn_pkg::REG_SBOX: sbox_cfg = val;
            spn_pkg::REG_PERM: perm_cfg = val;
            default:  ;
        endcase
    endtask

    // drain, then load all three registers, optionally also writing the spare index
    task automatic load_setting(
        input logic [spn_pkg::TABLE_W-1:0] key_word,
        input logic [spn_pkg::TABLE_W-1:0] sbox_word,
        input logic [spn_pkg::TABLE_W-1:0] perm_word,
        input bit                          poke_spare
    );
        wait_idle();
        write_reg(spn_pkg::REG_KEY, key_word);
        write_reg(spn_pkg::REG_SBOX, sbox_word);
        write_reg(spn_pkg::REG_PERM, perm_word);
        if (poke_spare)
            write_reg(REG_SPARE, random_word64());
        @(posedge clk);
        wr_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [spn_pkg::TABLE_W-1:0] key_word;
        logic [spn_pkg::TABLE_W-1:0] sbox_word;
        logic [spn_pkg::TABLE_W-1:0] perm_word;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // defaults straight out of reset
        plain_pending.push_back(16'h0000);
        plain_pending.push_back(16'hFFFF);
        plain_pending.push_back(16'h8000);
        plain_pending.push_back(16'h0001);
        plain_pending.push_back(16'h1234);
        plain_pending.push_back(16'h5A5A);

        // key upper data bits set and ignored; spare index written
        load_setting(64'hFFFF_FFFF_A5C3_1E97, spn_pkg::SBOX_RESET, spn_pkg::PERM_RESET,
                     1'b1);
        plain_pending.push_back(16'h0000);
        plain_pending.push_back(16'hFFFF);
        plain_pending.push_back(16'h7FFE);

        // all-zero S-box leaves only the last round key; identity wiring
        load_setting(64'hFFFF_FFFF, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b0);
        plain_pending.push_back(16'h0000);
        plain_pending.push_back(16'hFFFF);

        // every position sent to 0: last one wins, the rest read as zero
        load_setting(64'h0, {spn_pkg::TABLE_W{1'b1}}, 64'h0, 1'b0);
        plain_pending.push_back(16'h0000);
        plain_pending.push_back(16'hFFFF);
        plain_pending.push_back(16'h0001);

        // every position sent to 15
        load_setting(64'($urandom), spn_pkg::SBOX_RESET, {spn_pkg::TABLE_W{1'b1}}, 1'b0);
        plain_pending.push_back(16'h8000);
        plain_pending.push_back(16'h0001);
        plain_pending.push_back(16'hFFFF);

        // pairs share a destination, lower half of the outputs never named
        load_setting(64'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 64'h0011_2233_4455_6677, 1'b0);
        plain_pending.push_back(16'h0000);
        plain_pending.push_back(16'hFFFF);
        plain_pending.push_back(16'hA5A5);
        plain_pending.push_back(16'h3C3C);

        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       key_word = 64'h0;
                1:       key_word = 64'hFFFF_FFFF;
                default: key_word = random_word64();
            endcase
            case ($urandom_range(0, 4))
                0:       sbox_word = spn_pkg::SBOX_RESET;
                1:       sbox_word = random_word64();
                default: sbox_word = shuffled_table();
            endcase
            case ($urandom_range(0, 4))
                0:       perm_word = spn_pkg::PERM_RESET;
                1:       perm_word = random_word64();
                default: perm_word = shuffled_table();
            endcase
            load_setting(key_word, sbox_word, perm_word, ($urandom_range(0, 3) == 0));
            for (int n = 0; n < 55; n++)
            begin
                case ($urandom_range(0, 15))
                    0:       plain_pending.push_back(16'h0000);
                    1:       plain_pending.push_back(16'hFFFF);
                    default: plain_pending.push_back(16'($urandom_range(0, 65535)));
                endcase
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Encrypted %0d blocks under %0d key/table settings, %0d checked.",
                 blocks_sent, settings_used, blocks_checked);
        $display("Settings included zero and all-ones key, S-box and wiring tables.");
        if (mismatch_count == 0)
            $display("spn_block_encrypt_16bit_test passed");
        else
            $display("spn_block_encrypt_16bit_test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d requests pending, %0d results outstanding.",
                 plain_pending.size(), cipher_expected.size());
        $display("spn_block_encrypt_16bit_test failed");
        $finish;
    end

endmodule
